// File: hdl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and constants of the ASCII integer parser: status codes,
// radix codes, configuration register indexes and the classified beat.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int RESULT_W    = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int BASES_W     = 4;
    localparam int RBITS_W     = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BASE   = 3'd2,
        ST_CHAR   = 3'd3,
        ST_DIGIT  = 3'd4,
        ST_BOUNDS = 3'd5,
        ST_NEGU   = 3'd6,
        ST_SIZE   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALLOWED_BASES = 3'd0,
        CFG_SIGNED_RESULT = 3'd1,
        CFG_RESULT_BITS   = 3'd2,
        CFG_LOWER_BOUND   = 3'd3,
        CFG_UPPER_BOUND   = 3'd4
    } cfg_index_t;

    // One character after classification.
    typedef struct packed {
        logic       blank;
        logic       plus;
        logic       minus;
        logic       zero;
        logic       digit;
        logic [3:0] digit_val;
        logic [3:0] fits;          // digit is below the radix, indexed by radix_t
        logic       prefix;
        radix_t     prefix_radix;
        logic       separator;
        logic       last;
    } char_class_t;

    // Parse outcome handed from the sequencer to the bounds check.
    typedef struct packed {
        status_t status;
        logic    negative;
    } snap_t;

endpackage

// File: hdl/aip_if.sv
// ----------------------------------------------------------------------------
// aip_if
// Valid/ready channels of the parser: one for text characters, one for
// parse results.
// ----------------------------------------------------------------------------
interface aip_char_if import aip_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface aip_result_if import aip_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RESULT_W-1:0] result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);
endinterface

// File: hdl/aip_classify.sv
// ----------------------------------------------------------------------------
// aip_classify
// Front stage: take a character beat, classify it and hold it in a register
// until the queue takes it.
// ----------------------------------------------------------------------------
module aip_classify import aip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    aip_char_if.sink    char_stream,
    output logic        cls_valid,
    output char_class_t cls_data,
    input  logic        cls_ready
);

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UO    = 8'h4F;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO    = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] UPPER_OFS = 8'h37;  // 'A' - 10
    localparam logic [CHAR_W-1:0] LOWER_OFS = 8'h57;  // 'a' - 10

    function automatic char_class_t classify(input logic [CHAR_W-1:0] c, input logic last);
        char_class_t k;
        logic [3:0]  d;
        logic        is_dig;
        k      = '0;
        d      = '0;
        is_dig = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            is_dig = 1'b1;
            d      = 4'(c - CH_ZERO);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            is_dig = 1'b1;
            d      = 4'(c - LOWER_OFS);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            is_dig = 1'b1;
            d      = 4'(c - UPPER_OFS);
        end
        k.blank     = (c == CH_SPACE) || (c == CH_TAB);
        k.plus      = (c == CH_PLUS);
        k.minus     = (c == CH_MINUS);
        k.zero      = (c == CH_ZERO);
        k.digit     = is_dig;
        k.digit_val = d;
        k.fits      = {is_dig, is_dig && (d < 4'd10), is_dig && (d < 4'd8),
                       is_dig && (d < 4'd2)};
        k.separator = (c == CH_UNDER) || (c == CH_APOS);
        k.last      = last;
        if (c == CH_LX || c == CH_UX)
        begin
            k.prefix       = 1'b1;
            k.prefix_radix = RADIX_HEX;
        end
        else if (c == CH_LO || c == CH_UO)
        begin
            k.prefix       = 1'b1;
            k.prefix_radix = RADIX_OCT;
        end
        else if (c == CH_LB || c == CH_UB)
        begin
            k.prefix       = 1'b1;
            k.prefix_radix = RADIX_BIN;
        end
        return k;
    endfunction

    logic        valid_reg;
    char_class_t data_reg;

    assign char_stream.ready = !valid_reg || cls_ready;
    assign cls_valid         = valid_reg;
    assign cls_data          = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (char_stream.ready)
        begin
            valid_reg <= char_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_stream.valid && char_stream.ready)
        begin
            data_reg <= classify(char_stream.character, char_stream.last_char);
        end
    end

endmodule

// File: hdl/aip_queue.sv
// ----------------------------------------------------------------------------
// aip_queue
// Short queue of classified beats between the front stage and the sequencer.
// ----------------------------------------------------------------------------
module aip_queue import aip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    input  char_class_t push_data,
    output logic        push_ready,
    output logic        pop_valid,
    output char_class_t pop_data,
    input  logic        pop_ready
);

    localparam logic [QUEUE_PTR_W-1:0] LAST_SLOT = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] FULL_CNT  = QUEUE_CNT_W'(QUEUE_DEPTH);

    char_class_t             slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]  count_reg;
    logic                    push;
    logic                    pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/aip_exec.sv
// ----------------------------------------------------------------------------
// aip_exec
// Back stage: phase sequencer, radix prefix handling and digit accumulation.
// On the last character it hands the parse outcome to the bounds check.
// ----------------------------------------------------------------------------
module aip_exec import aip_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [BASES_W-1:0]     allowed_bases,
    input  logic                   cls_valid,
    input  char_class_t            cls_data,
    output logic                   cls_ready,
    output logic                   snap_valid,
    output snap_t                  snap,
    output logic [VALUE_WIDTH-1:0] snap_acc,
    input  logic                   snap_ready
);

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_TRAIL  = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    radix_t                 radix_reg, radix_next;
    status_t                err_reg, err_next;

    logic                   snap_valid_reg;
    snap_t                  snap_reg;
    logic [VALUE_WIDTH-1:0] snap_acc_reg;

    radix_t                 eff_radix;
    logic [VALUE_WIDTH-1:0] digit_ext;
    logic [VALUE_WIDTH-1:0] mac;
    logic                   take;
    logic                   dec_ok;
    logic                   pop;
    logic                   snap_free;
    status_t                fin_status;

    assign snap_free  = !snap_valid_reg || snap_ready;
    assign cls_ready  = !cls_data.last || snap_free;
    assign pop        = cls_valid && cls_ready;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;
    assign snap_acc   = snap_acc_reg;

    // Digits before the digit phase always go in as decimal.
    assign eff_radix = (phase_reg == PH_DIGITS) ? radix_reg : RADIX_DEC;
    assign digit_ext = VALUE_WIDTH'(cls_data.digit_val);
    assign dec_ok    = allowed_bases[RADIX_DEC];

    always_comb
    begin
        case (eff_radix)
            RADIX_BIN: mac = (acc_reg << 1) + digit_ext;
            RADIX_OCT: mac = (acc_reg << 3) + digit_ext;
            RADIX_DEC: mac = (acc_reg << 3) + (acc_reg << 1) + digit_ext;
            default:   mac = (acc_reg << 4) + digit_ext;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        err_next   = err_reg;
        take       = 1'b0;
        if (err_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (cls_data.blank)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (cls_data.plus || cls_data.minus)
                    begin
                        neg_next   = cls_data.minus;
                        phase_next = PH_SIGN;
                    end
                    else if (cls_data.zero)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        radix_next = RADIX_DEC;
                        phase_next = PH_DIGITS;
                        if (!dec_ok) err_next = ST_BASE;
                        else         take     = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    if (cls_data.zero)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        radix_next = RADIX_DEC;
                        if (!dec_ok) err_next = ST_BASE;
                        if (cls_data.blank)
                        begin
                            phase_next = PH_TRAIL;
                        end
                        else
                        begin
                            phase_next = PH_DIGITS;
                            take       = dec_ok;
                        end
                    end
                end
                PH_ZERO:
                begin
                    phase_next = PH_DIGITS;
                    if (cls_data.prefix)
                    begin
                        radix_next = cls_data.prefix_radix;
                        if (!allowed_bases[cls_data.prefix_radix]) err_next = ST_BASE;
                    end
                    else
                    begin
                        radix_next = RADIX_DEC;
                        if (!dec_ok) err_next = ST_BASE;
                        if (cls_data.blank) phase_next = PH_TRAIL;
                        else                take       = dec_ok;
                    end
                end
                PH_DIGITS:
                begin
                    if (cls_data.blank) phase_next = PH_TRAIL;
                    else                take       = 1'b1;
                end
                PH_TRAIL:
                begin
                    if (!cls_data.blank) err_next = ST_CHAR;
                end
                default:
                begin
                    phase_next = PH_LEAD;
                end
            endcase

            if (take)
            begin
                if (cls_data.digit)
                begin
                    if (cls_data.fits[eff_radix]) acc_next = mac;
                    else                          err_next = ST_DIGIT;
                end
                else if (!cls_data.separator)
                begin
                    err_next = ST_CHAR;
                end
            end
        end
    end

    // Close out the text: blanks only, or a lone sign or zero taken as decimal.
    always_comb
    begin
        if (err_next != ST_OK)
        begin
            fin_status = err_next;
        end
        else if (phase_next == PH_LEAD)
        begin
            fin_status = ST_EMPTY;
        end
        else if ((phase_next == PH_SIGN || phase_next == PH_ZERO) && !dec_ok)
        begin
            fin_status = ST_BASE;
        end
        else
        begin
            fin_status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            radix_reg      <= RADIX_DEC;
            err_reg        <= ST_OK;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && cls_data.last)
            begin
                phase_reg      <= PH_LEAD;
                acc_reg        <= '0;
                neg_reg        <= 1'b0;
                radix_reg      <= RADIX_DEC;
                err_reg        <= ST_OK;
                snap_valid_reg <= 1'b1;
            end
            else
            begin
                if (pop)
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    neg_reg   <= neg_next;
                    radix_reg <= radix_next;
                    err_reg   <= err_next;
                end
                if (snap_ready)
                begin
                    snap_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && cls_data.last)
        begin
            snap_reg.status   <= fin_status;
            snap_reg.negative <= neg_next;
            snap_acc_reg      <= acc_next;
        end
    end

endmodule

// File: hdl/aip_check.sv
// ----------------------------------------------------------------------------
// aip_check
// Result stage: apply sign, check bounds and size, and hold the result beat
// in the output register.
// ----------------------------------------------------------------------------
module aip_check import aip_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   signed_result,
    input  logic [RBITS_W-1:0]     result_bits,
    input  logic [CFG_DATA_W-1:0]  lower_bound,
    input  logic [CFG_DATA_W-1:0]  upper_bound,
    input  logic                   snap_valid,
    input  snap_t                  snap,
    input  logic [VALUE_WIDTH-1:0] snap_acc,
    output logic                   snap_ready,
    aip_result_if.source           result_stream
);

    localparam logic [RESULT_W-1:0] ONE       = RESULT_W'(1);
    localparam logic [RESULT_W-1:0] SMAX_FULL = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic [RBITS_W-1:0]  W_FULL    = RBITS_W'(RESULT_W);
    localparam logic [RBITS_W-1:0]  W_ONE     = RBITS_W'(1);
    localparam logic [RBITS_W-1:0]  W8        = RBITS_W'(8);
    localparam logic [RBITS_W-1:0]  W16       = RBITS_W'(16);
    localparam logic [RBITS_W-1:0]  W32       = RBITS_W'(32);

    // Effective limits follow the registers; the user must change them only while idle, the block does not enforce it.
    logic [RBITS_W-1:0]  w_eff;
    logic                wide;
    logic [RESULT_W-1:0] umax;
    logic [RESULT_W-1:0] smax;
    logic [RESULT_W-1:0] smin;
    logic [RESULT_W-1:0] min_next;
    logic [RESULT_W-1:0] max_next;
    logic                known_next;
    logic [RESULT_W-1:0] mask_next;

    logic [RESULT_W-1:0] min_reg;
    logic [RESULT_W-1:0] max_reg;
    logic                signed_reg;
    logic                known_reg;
    logic [RESULT_W-1:0] mask_reg;

    logic [RESULT_W-1:0] val;
    logic [RESULT_W-1:0] sv;
    logic                below;
    logic                above;
    logic                negu;
    status_t             status_next;
    logic [RESULT_W-1:0] value_next;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [RESULT_W-1:0] value_reg;
    logic                take;

    assign w_eff = (result_bits == '0) ? W_ONE : result_bits;
    assign wide  = (w_eff >= W_FULL);
    assign umax  = wide ? '1 : (ONE << w_eff[5:0]) - ONE;
    assign smax  = wide ? SMAX_FULL : (ONE << (w_eff[5:0] - 6'd1)) - ONE;
    assign smin  = ~smax;

    always_comb
    begin
        if (signed_result)
        begin
            min_next = ($signed(lower_bound) > $signed(smin)) ? lower_bound : smin;
            max_next = (upper_bound < smax) ? upper_bound : smax;
        end
        else
        begin
            min_next = lower_bound[CFG_DATA_W-1] ? '0 : lower_bound;
            max_next = (upper_bound < umax) ? upper_bound : umax;
        end
    end

    always_comb
    begin
        known_next = 1'b1;
        unique case (result_bits)
            W8:      mask_next = RESULT_W'(8'hFF);
            W16:     mask_next = RESULT_W'(16'hFFFF);
            W32:     mask_next = RESULT_W'(32'hFFFF_FFFF);
            W_FULL:  mask_next = '1;
            default:
            begin
                known_next = 1'b0;
                mask_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        min_reg    <= min_next;
        max_reg    <= max_next;
        signed_reg <= signed_result;
        known_reg  <= known_next;
        mask_reg   <= mask_next;
    end

    assign val   = RESULT_W'(snap_acc);
    assign sv    = snap.negative ? (RESULT_W'(0) - val) : val;
    assign below = signed_reg ? ($signed(sv) < $signed(min_reg)) : (sv < min_reg);
    assign above = signed_reg ? (!sv[RESULT_W-1] && (sv > max_reg)) : (sv > max_reg);
    assign negu  = !signed_reg && snap.negative && (val != '0);

    always_comb
    begin
        value_next = '0;
        if (snap.status != ST_OK)
        begin
            status_next = snap.status;
        end
        else if (negu)
        begin
            status_next = ST_NEGU;
        end
        else if (below || above)
        begin
            status_next = ST_BOUNDS;
        end
        else if (!known_reg)
        begin
            status_next = ST_SIZE;
        end
        else
        begin
            status_next = ST_OK;
            value_next  = sv & mask_reg;
        end
    end

    assign snap_ready                 = !out_valid_reg || result_stream.ready;
    assign take                       = snap_valid && snap_ready;
    assign result_stream.valid        = out_valid_reg;
    assign result_stream.status       = status_reg;
    assign result_stream.result_value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            out_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

endmodule

// File: hdl/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming parser of one integer per text, one ASCII character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   char_stream carries one character per beat with last_char on the final
//   one. Text may hold blanks around the number, a sign, a 0x/0o/0b prefix
//   and '_' or apostrophe separators. Send an empty text as a single space.
//   result_stream carries one beat per text: status and result_value.
//   The cfg_write/cfg_index/cfg_data port sets allowed bases, sign mode,
//   result width and bounds; write it only while no text is in flight.
// Timing:
//   One character per cycle, sustained, while the receiver keeps up. The
//   result beat passes the classify register, queue, sequencer snapshot
//   and output register after the last character is taken. The digit
//   multiply-add by the radix sets the cycle.
// Reset and stall:
//   rst_n clears all parse state and loads the register defaults. When the
//   receiver holds ready low, the output register holds its beat, the two
//   deep queue fills and then char_stream.ready drops.
// ----------------------------------------------------------------------------
module ascii_integer_parser import aip_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    aip_char_if.sink               char_stream,
    aip_result_if.source           result_stream
);

    // Configuration registers.
    logic [BASES_W-1:0]    allowed_bases_reg;
    logic                  signed_result_reg;
    logic [RBITS_W-1:0]    result_bits_reg;
    logic [CFG_DATA_W-1:0] lower_bound_reg;
    logic [CFG_DATA_W-1:0] upper_bound_reg;

    // Front stage to queue.
    logic        cls_valid;
    char_class_t cls_data;
    logic        cls_ready;

    // Queue to sequencer.
    logic        q_valid;
    char_class_t q_data;
    logic        q_ready;

    // Sequencer to result stage.
    logic                   snap_valid;
    snap_t                  snap;
    logic [VALUE_WIDTH-1:0] snap_acc;
    logic                   snap_ready;

    // Latch a register write; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allowed_bases_reg <= '1;
            signed_result_reg <= 1'b0;
            result_bits_reg   <= RBITS_W'(32);
            lower_bound_reg   <= {1'b1, {(CFG_DATA_W-1){1'b0}}};
            upper_bound_reg   <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ALLOWED_BASES: allowed_bases_reg <= cfg_data[BASES_W-1:0];
                CFG_SIGNED_RESULT: signed_result_reg <= cfg_data[0];
                CFG_RESULT_BITS:   result_bits_reg   <= cfg_data[RBITS_W-1:0];
                CFG_LOWER_BOUND:   lower_bound_reg   <= cfg_data;
                CFG_UPPER_BOUND:   upper_bound_reg   <= cfg_data;
                default:
                begin
                    allowed_bases_reg <= allowed_bases_reg;
                end
            endcase
        end
    end

    // Classify each character beat.
    aip_classify u_classify
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_stream),
        .cls_valid   (cls_valid),
        .cls_data    (cls_data),
        .cls_ready   (cls_ready)
    );

    // Decouple the front stage from the sequencer.
    aip_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_data  (cls_data),
        .push_ready (cls_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop_ready  (q_ready)
    );

    // Advance the phase machine and accumulate digits.
    aip_exec #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_exec
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .allowed_bases (allowed_bases_reg),
        .cls_valid     (q_valid),
        .cls_data      (q_data),
        .cls_ready     (q_ready),
        .snap_valid    (snap_valid),
        .snap          (snap),
        .snap_acc      (snap_acc),
        .snap_ready    (snap_ready)
    );

    // Check sign, bounds and size, and hold the result beat.
    aip_check #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .signed_result (signed_result_reg),
        .result_bits   (result_bits_reg),
        .lower_bound   (lower_bound_reg),
        .upper_bound   (upper_bound_reg),
        .snap_valid    (snap_valid),
        .snap          (snap),
        .snap_acc      (snap_acc),
        .snap_ready    (snap_ready),
        .result_stream (result_stream)
    );

endmodule

// File: tb/tb_ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser
// Self-checking bench of the ASCII integer parser. A directed table covers
// blanks, signs, every prefix, separators, error codes but ST_SIZE and the base
// checks. Random texts follow over a series of register settings; most are
// well-formed numbers, often near a bound, the rest noise and broken text. A
// local parse model predicts each result. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser import aip_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD  = 2;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASE_CHARS  = 75;     // least characters per register setting
    localparam int          PHASE_COUNT  = 9;
    localparam int          MAX_PRINTS   = 50;
    localparam longint      LIMIT_NS     = 2_000_000;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_APOS      = 8'h27;
    localparam logic [63:0] S64_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

    // Phases of the local parse model.
    typedef enum logic [2:0] {
        P_LEAD   = 3'd0,
        P_SIGN   = 3'd1,
        P_ZERO   = 3'd2,
        P_DIGITS = 3'd3,
        P_TRAIL  = 3'd4
    } text_phase_t;

    typedef struct {
        status_t     st;
        logic [63:0] val;
    } text_outcome_t;

    typedef struct {
        logic [3:0]  bases;
        string       text;
        bit          pinned;
        status_t     st;
        logic [63:0] val;
    } text_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    aip_char_if   cin ();
    aip_result_if rout ();

    ascii_integer_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .char_stream   (cin),
        .result_stream (rout)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Register copies kept by the parse model.
    logic [3:0]  cfg_bases;
    logic        cfg_signed;
    logic [6:0]  cfg_width;
    logic [63:0] cfg_lo;
    logic [63:0] cfg_hi;

    // Parse state of the text in flight.
    text_phase_t ph;
    logic [63:0] acc;
    logic        neg;
    radix_t      rdx;
    status_t     err;

    text_outcome_t pending_results[$];
    logic [7:0]    text_buf[$];
    text_row_t     text_rows[$];

    // Expectation typed into the directed table overrides the model's.
    bit            pinned_on;
    text_outcome_t pinned_outcome;

    int fail_count;
    int chars_sent;
    int texts_sent;
    int results_seen;
    int setting_count;
    logic [7:0] status_seen;

    // Sender burst shaping and receiver stall pattern.
    int burst_left;
    int gap_len;
    int stall_mode;
    int mode_left;
    int hold_left;
    int stall_tick;

    // ------------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] low_mask(input logic [6:0] w);
        return (w >= 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic void clear_text();
        ph  = P_LEAD;
        acc = '0;
        neg = 1'b0;
        rdx = RADIX_DEC;
        err = ST_OK;
    endfunction

    // Settle the base; a disallowed base latches the base error.
    function automatic void pick_radix(input radix_t r);
        rdx = r;
        if (!cfg_bases[r])
            err = ST_BASE;
    endfunction

    function automatic void fold_digit(input logic [7:0] c);
        logic [7:0] d;
        logic [7:0] base_n;
        case (rdx)
            RADIX_BIN: base_n = 8'd2;
            RADIX_OCT: base_n = 8'd8;
            RADIX_DEC: base_n = 8'd10;
            default:   base_n = 8'd16;
        endcase
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (c >= "a" && c <= "f")
            d = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            d = c - "A" + 8'd10;
        else if (c == "_" || c == CH_APOS)
            return;
        else
        begin
            err = ST_CHAR;
            return;
        end
        if (d >= base_n)
        begin
            err = ST_DIGIT;
            return;
        end
        acc = acc * base_n + d;
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        if (err != ST_OK)
            return;
        case (ph)
            P_LEAD:
            begin
                if (is_blank(c))
                    return;
                if (c == "+" || c == "-")
                begin
                    neg = (c == "-");
                    ph  = P_SIGN;
                    return;
                end
                if (c == "0")
                begin
                    ph = P_ZERO;
                    return;
                end
                pick_radix(RADIX_DEC);
                ph = P_DIGITS;
                if (err == ST_OK)
                    fold_digit(c);
            end
            P_SIGN:
            begin
                if (c == "0")
                begin
                    ph = P_ZERO;
                    return;
                end
                pick_radix(RADIX_DEC);
                if (is_blank(c))
                begin
                    ph = P_TRAIL;
                    return;
                end
                ph = P_DIGITS;
                if (err == ST_OK)
                    fold_digit(c);
            end
            P_ZERO:
            begin
                ph = P_DIGITS;
                if (c == "x" || c == "X")
                    pick_radix(RADIX_HEX);
                else if (c == "o" || c == "O")
                    pick_radix(RADIX_OCT);
                else if (c == "b" || c == "B")
                    pick_radix(RADIX_BIN);
                else
                begin
                    pick_radix(RADIX_DEC);
                    if (is_blank(c))
                        ph = P_TRAIL;
                    else if (err == ST_OK)
                        fold_digit(c);
                end
            end
            P_DIGITS:
            begin
                if (is_blank(c))
                    ph = P_TRAIL;
                else
                    fold_digit(c);
            end
            default:
            begin
                if (!is_blank(c))
                    err = ST_CHAR;
            end
        endcase
    endfunction

    // Status and value of the finished text, after the bounds check.
    function automatic text_outcome_t conclude_parse();
        text_outcome_t      o;
        logic [6:0]         w;
        logic [63:0]        sv;
        logic [63:0]        tmax;
        logic [63:0]        emax;
        logic [63:0]        umin;
        logic signed [63:0] s;
        logic signed [63:0] lb;
        logic signed [63:0] tmin;
        logic signed [63:0] emin;
        bit                 known;
        o.st  = ST_OK;
        o.val = '0;
        w     = (cfg_width == 7'd0) ? 7'd1 : cfg_width;
        known = cfg_width == 7'd8 || cfg_width == 7'd16 || cfg_width == 7'd32
                || cfg_width == 7'd64;
        if (err == ST_OK)
        begin
            if (ph == P_LEAD)
            begin
                o.st = ST_EMPTY;
                return o;
            end
            // a lone sign or zero counts as decimal
            if (ph == P_SIGN || ph == P_ZERO)
                pick_radix(RADIX_DEC);
        end
        if (err != ST_OK)
        begin
            o.st = err;
            return o;
        end
        if (cfg_signed)
        begin
            sv   = neg ? -acc : acc;
            s    = sv;
            lb   = cfg_lo;
            tmax = (w < 7'd64) ? ((64'd1 << (w - 7'd1)) - 64'd1) : S64_MAX;
            tmin = -$signed(tmax) - 1;
            emin = (lb > tmin) ? lb : tmin;
            emax = (cfg_hi < tmax) ? cfg_hi : tmax;
            if (s < emin || (s >= 0 && sv > emax))
                o.st = ST_BOUNDS;
            else if (!known)
                o.st = ST_SIZE;
            else
                o.val = sv & low_mask(cfg_width);
        end
        else
        begin
            tmax = low_mask(w);
            emax = (cfg_hi < tmax) ? cfg_hi : tmax;
            umin = cfg_lo[63] ? 64'd0 : cfg_lo;
            if (neg && acc != 64'd0)
                o.st = ST_NEGU;
            else if (acc < umin || acc > emax)
                o.st = ST_BOUNDS;
            else if (!known)
                o.st = ST_SIZE;
            else
                o.val = acc & low_mask(cfg_width);
        end
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < MAX_PRINTS)
            $display("%0t ns: %s on result %0d: got 0x%0h, want 0x%0h",
                     $time, what, results_seen, got, want);
        fail_count++;
    endtask

    // Compare every result beat with the oldest expectation.
    always @(posedge clk)
    begin
        text_outcome_t want;
        if (rst_n === 1'b1 && rout.valid === 1'b1 && rout.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 64'(rout.status), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (rout.status !== want.st)
                    report_mismatch("status", 64'(rout.status), 64'(want.st));
                if (rout.result_value !== want.val)
                    report_mismatch("result_value", rout.result_value, want.val);
            end
            status_seen[rout.status] = 1'b1;
            results_seen++;
        end
    end

    // Receiver: switch between free flow, coin-flip, periodic and long stalls.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
            0: rout.ready <= 1'b1;
            1: rout.ready <= 1'($urandom_range(0, 1));
            2: rout.ready <= (stall_tick % 4 == 0);
            default:
            begin
                if (hold_left > 0)
                begin
                    rout.ready <= 1'b0;
                    hold_left--;
                end
                else
                begin
                    rout.ready <= 1'b1;
                    if ($urandom_range(0, 2) == 0)
                        hold_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Send one character beat; start and end at a falling edge.
    task automatic send_beat(input logic [7:0] ch, input logic last);
        text_outcome_t got;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap_len > 0)
            begin
                cin.valid <= 1'b0;
                repeat (gap_len) @(negedge clk);
            end
        end
        burst_left--;
        cin.valid     <= 1'b1;
        cin.character <= ch;
        cin.last_char <= last;
        @(posedge clk);
        while (cin.ready !== 1'b1)
            @(posedge clk);
        absorb_char(ch);
        chars_sent++;
        if (last)
        begin
            got = conclude_parse();
            clear_text();
            pending_results.push_back(pinned_on ? pinned_outcome : got);
            texts_sent++;
        end
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_beat(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Hold valid low until every expected result is back, then let the pipe settle.
    task automatic wait_idle();
        cin.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_ALLOWED_BASES: cfg_bases  = data[3:0];
            CFG_SIGNED_RESULT: cfg_signed = data[0];
            CFG_RESULT_BITS:   cfg_width  = data[6:0];
            CFG_LOWER_BOUND:   cfg_lo     = data;
            CFG_UPPER_BOUND:   cfg_hi     = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic add_row(input logic [3:0] bases, input string text, input bit pinned,
                           input status_t st, input logic [63:0] val);
        text_row_t r;
        r.bases  = bases;
        r.text   = text;
        r.pinned = pinned;
        r.st     = st;
        r.val    = val;
        text_rows.push_back(r);
    endtask

    function automatic logic [7:0] rand_blank();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    // Fill text_buf with a well-formed number, often close to a bound.
    task automatic make_number_text();
        logic [63:0] mag;
        logic [63:0] t;
        logic [6:0]  w;
        logic [7:0]  c;
        radix_t      r;
        bit          minus;
        string       digs;
        int          pick;
        text_buf.delete();
        pick  = $urandom_range(0, 9);
        r     = (pick < 2) ? RADIX_BIN : (pick < 4) ? RADIX_OCT
              : (pick < 7) ? RADIX_DEC : RADIX_HEX;
        w     = (cfg_width == 7'd0) ? 7'd1 : cfg_width;
        minus = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 3))
            0: mag = {$urandom, $urandom};
            1: mag = {$urandom, $urandom} & low_mask(7'($urandom_range(1, 64)));
            2:
            begin
                // aim at a bound, then nudge by up to two either way
                pick = $urandom_range(0, 3);
                case (pick)
                    0: t = cfg_lo;
                    1: t = cfg_hi;
                    2: t = cfg_signed ? (low_mask(w) >> 1) : low_mask(w);
                    default: t = ~(low_mask(w) >> 1);
                endcase
                t = t + 64'($urandom_range(0, 4)) - 64'd2;
                if (pick == 0 || pick == 3)
                begin
                    minus = t[63];
                    mag   = t[63] ? -t : t;
                end
                else
                begin
                    minus = 1'b0;
                    mag   = t;
                end
            end
            default: mag = 64'($urandom_range(0, 99));
        endcase
        // keep most binary texts short
        if (r == RADIX_BIN && $urandom_range(0, 3) != 0)
            mag = mag & 64'hFFFF;
        case (r)
            RADIX_BIN: digs = $sformatf("%0b", mag);
            RADIX_OCT: digs = $sformatf("%0o", mag);
            RADIX_DEC: digs = $sformatf("%0d", mag);
            default:   digs = $sformatf("%0h", mag);
        endcase
        repeat ($urandom_range(0, 2)) text_buf.push_back(rand_blank());
        if (minus)
            text_buf.push_back("-");
        else if ($urandom_range(0, 3) == 0)
            text_buf.push_back("+");
        if (r != RADIX_DEC)
        begin
            text_buf.push_back("0");
            case (r)
                RADIX_BIN: c = "b";
                RADIX_OCT: c = "o";
                default:   c = "x";
            endcase
            text_buf.push_back($urandom_range(0, 1) ? c - 8'h20 : c);
        end
        else if ($urandom_range(0, 5) == 0)
            text_buf.push_back("0");
        for (int i = 0; i < digs.len(); i++)
        begin
            if (i > 0 && $urandom_range(0, 7) == 0)
                text_buf.push_back($urandom_range(0, 1) ? 8'(CH_APOS) : 8'("_"));
            c = digs[i];
            if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1)
                c = c - 8'h20;
            text_buf.push_back(c);
        end
        repeat ($urandom_range(0, 2)) text_buf.push_back(rand_blank());
    endtask

    // Fill text_buf with noise or a broken number.
    task automatic make_noise_text();
        int pos;
        int n;
        case ($urandom_range(0, 4))
            0:
            begin
                text_buf.delete();
                n = $urandom_range(1, 6);
                repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
            end
            1:
            begin
                make_number_text();
                pos = $urandom_range(0, text_buf.size() - 1);
                text_buf[pos] = 8'($urandom_range(0, 255));
            end
            2:
            begin
                make_number_text();
                pos = $urandom_range(0, text_buf.size() - 1);
                text_buf.insert(pos, rand_blank());
            end
            3:
            begin
                text_buf.delete();
                n = $urandom_range(1, 3);
                repeat (n) text_buf.push_back(rand_blank());
            end
            default:
            begin
                // lone sign, zero or prefix, sometimes doubled signs
                text_buf.delete();
                if ($urandom_range(0, 1))
                    text_buf.push_back($urandom_range(0, 1) ? 8'("+") : 8'("-"));
                if ($urandom_range(0, 4) == 0)
                    text_buf.push_back("-");
                if ($urandom_range(0, 2) != 0)
                begin
                    text_buf.push_back("0");
                    case ($urandom_range(0, 6))
                        0: text_buf.push_back("x");
                        1: text_buf.push_back("X");
                        2: text_buf.push_back("o");
                        3: text_buf.push_back("O");
                        4: text_buf.push_back("b");
                        5: text_buf.push_back("B");
                        default: ;
                    endcase
                end
                if (text_buf.size() == 0)
                    text_buf.push_back(CH_SPACE);
            end
        endcase
    endtask

    // Register setting of one random phase; the first ones pin extremes.
    task automatic apply_setting(input int p);
        logic [3:0]  b;
        logic        s;
        logic [6:0]  w;
        logic [63:0] lo;
        logic [63:0] hi;
        case (p)
            0: begin b = 4'hF; s = 1'b1; w = 7'd64; lo = S64_MIN; hi = '1; end
            1: begin b = 4'hF; s = 1'b0; w = 7'd8;  lo = 64'd3;   hi = 64'd200; end
            2: begin b = 4'hF; s = 1'b1; w = 7'd16; lo = -64'd100; hi = 64'd1000; end
            3: begin b = 4'h5; s = 1'b1; w = 7'd1;  lo = S64_MIN; hi = '1; end
            4: begin b = 4'h0; s = 1'b0; w = 7'd64; lo = S64_MAX; hi = 64'd0; end
            5: begin b = 4'hF; s = 1'b0; w = 7'd64; lo = 64'd0;   hi = '1; end
            6: begin b = 4'hF; s = 1'b1; w = 7'd63; lo = S64_MIN; hi = S64_MAX; end
            default:
            begin
                b = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15));
                s = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 4))
                    0: w = 7'd8;
                    1: w = 7'd16;
                    2: w = 7'd32;
                    3: w = 7'd64;
                    default: w = 7'($urandom_range(1, 64));
                endcase
                case ($urandom_range(0, 3))
                    0: lo = S64_MIN;
                    1: lo = 64'd0;
                    2: lo = -64'($urandom_range(0, 1000));
                    default: lo = {$urandom, $urandom};
                endcase
                case ($urandom_range(0, 3))
                    0: hi = '1;
                    1: hi = 64'($urandom_range(0, 100000));
                    2: hi = S64_MAX;
                    default: hi = {$urandom, $urandom};
                endcase
            end
        endcase
        write_reg(CFG_ALLOWED_BASES, {60'd0, b});
        write_reg(CFG_SIGNED_RESULT, {63'd0, s});
        write_reg(CFG_RESULT_BITS, {57'd0, w});
        write_reg(CFG_LOWER_BOUND, lo);
        write_reg(CFG_UPPER_BOUND, hi);
        setting_count++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_start;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cin.valid     = 1'b0;
        cin.character = '0;
        cin.last_char = 1'b0;
        rout.ready    = 1'b0;
        cfg_bases     = 4'hF;
        cfg_signed    = 1'b0;
        cfg_width     = 7'd32;
        cfg_lo        = S64_MIN;
        cfg_hi        = '1;
        clear_text();
        pinned_on     = 1'b0;
        fail_count    = 0;
        chars_sent    = 0;
        texts_sent    = 0;
        results_seen  = 0;
        setting_count = 1;
        status_seen   = '0;
        burst_left    = 0;
        mode_left     = 0;
        hold_left     = 0;
        stall_tick    = 0;

        // Directed table; the pinned rows carry their own expected result.
        add_row(4'hF, " ",                    1, ST_EMPTY,  64'd0);
        add_row(4'hF, "0",                    1, ST_OK,     64'd0);
        add_row(4'hF, "4294967295",           1, ST_OK,     64'hFFFF_FFFF);
        add_row(4'hF, "4294967296",           1, ST_BOUNDS, 64'd0);
        add_row(4'hF, "-7",                   1, ST_NEGU,   64'd0);
        add_row(4'hF, "-0",                   0, ST_OK,     64'd0);
        add_row(4'hF, "+",                    0, ST_OK,     64'd0);
        add_row(4'hF, "0x",                   0, ST_OK,     64'd0);
        add_row(4'hF, "0XfF",                 1, ST_OK,     64'd255);
        add_row(4'hF, "0b1011",               0, ST_OK,     64'd0);
        add_row(4'hF, "0O777",                0, ST_OK,     64'd0);
        add_row(4'hF, " \t+1_000'000 \t",     0, ST_OK,     64'd0);
        add_row(4'hF, "12 3",                 1, ST_CHAR,   64'd0);
        add_row(4'hF, "12g",                  1, ST_CHAR,   64'd0);
        add_row(4'hF, "- 5",                  0, ST_OK,     64'd0);
        add_row(4'hF, "0b102",                1, ST_DIGIT,  64'd0);
        add_row(4'hF, "0o8",                  1, ST_DIGIT,  64'd0);
        add_row(4'hF, "9a",                   1, ST_DIGIT,  64'd0);
        add_row(4'hF, "\377",                 1, ST_CHAR,   64'd0);
        add_row(4'hF, "18446744073709551621", 0, ST_OK,     64'd0);
        add_row(4'hF, "0xFFFFFFFFFFFFFFFF",   0, ST_OK,     64'd0);
        add_row(4'h7, "0x1",                  1, ST_BASE,   64'd0);
        add_row(4'h7, "0xZ",                  1, ST_BASE,   64'd0);
        add_row(4'hB, "0",                    1, ST_BASE,   64'd0);
        add_row(4'hB, "-",                    0, ST_OK,     64'd0);
        add_row(4'hE, "0b1",                  1, ST_BASE,   64'd0);
        add_row(4'hD, "0o5",                  1, ST_BASE,   64'd0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the table; change the allowed bases only with the pipe empty.
        foreach (text_rows[i])
        begin
            if (text_rows[i].bases != cfg_bases)
            begin
                wait_idle();
                write_reg(CFG_ALLOWED_BASES, {60'd0, text_rows[i].bases});
            end
            text_buf.delete();
            for (int k = 0; k < text_rows[i].text.len(); k++)
                text_buf.push_back(text_rows[i].text[k]);
            pinned_on          = text_rows[i].pinned;
            pinned_outcome.st  = text_rows[i].st;
            pinned_outcome.val = text_rows[i].val;
            send_text();
            pinned_on = 1'b0;
        end

        // Random phases, one register setting each; drain before every change.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            apply_setting(p);
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS)
            begin
                if ($urandom_range(0, 3) == 0)
                    make_noise_text();
                else
                    make_number_text();
                send_text();
                // now and then drop valid until every result is back
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (pending_results.size() != 0)
            report_mismatch("missing results", 64'(pending_results.size()), 64'd0);

        $display("Covered %0d texts, %0d characters, %0d register settings, %0d results.",
                 texts_sent, chars_sent, setting_count, results_seen);
        $display("Status codes returned (bit per code, 7 down to 0): %b", status_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #(LIMIT_NS);
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
